// File: rtl/cvt_pkg.sv
// Package for the compacting vector table.
// Holds field widths, parameter defaults, codes, FSM states and the
// command and status structs shared by the controller and the datapath.
package cvt_pkg;

  localparam int ACTION_W      = 2;
  localparam int POSITION_W    = 6;
  localparam int VALUE_W       = 32;
  localparam int READ_WORD_W   = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 7;

  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;
  localparam int INIT_CAP_DEF  = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_READ   = 2'd1,
    ACT_WRITE  = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_SHIFT  = 2'd2,
    S_RESULT = 2'd3
  } state_t;

  typedef struct packed {
    logic    in_ready;
    logic    load_in;
    logic    exec;
    status_t status;
    logic    do_append;
    logic    do_read;
    logic    do_write;
    logic    start_remove;
    logic    do_shift;
    logic    finish_remove;
    logic    load_out;
  } cvt_cmd_t;

  typedef struct packed {
    logic    in_valid;
    action_t action;
    logic    pos_bad;
    logic    table_full;
    logic    shift_more;
    logic    out_free;
  } cvt_stat_t;

endpackage

// File: rtl/cvt_if.sv
// Channel interfaces for the compacting vector table: request and result.
// Each carries valid, ready and the payload; widths come from cvt_pkg.
interface cvt_in_if;
  logic                            valid;
  logic                            ready;
  logic [cvt_pkg::ACTION_W-1:0]    action;
  logic [cvt_pkg::POSITION_W-1:0]  position;
  logic [cvt_pkg::VALUE_W-1:0]     value;

  modport source (output valid, action, position, value, input ready);
  modport sink (input valid, action, position, value, output ready);
endinterface

interface cvt_out_if;
  logic                             valid;
  logic                             ready;
  logic [cvt_pkg::READ_WORD_W-1:0]  read_word;
  logic [cvt_pkg::STATUS_W-1:0]     status;
  logic [cvt_pkg::COUNT_OUT_W-1:0]  entry_count;
  logic [cvt_pkg::COUNT_OUT_W-1:0]  capacity_now;

  modport source (output valid, read_word, status, entry_count, capacity_now,
                  input ready);
  modport sink (input valid, read_word, status, entry_count, capacity_now,
                output ready);
endinterface

// File: rtl/cvt_ctrl.sv
// Controller state machine of the compacting vector table.
// Reads datapath status and issues commands; uses cvt_pkg types.
module cvt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  cvt_pkg::cvt_stat_t stat,
  output cvt_pkg::cvt_cmd_t  cmd
);

  cvt_pkg::state_t state_r;
  cvt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cvt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cvt_pkg::S_IDLE: begin
        if (stat.in_valid) begin
          state_nxt = cvt_pkg::S_EXEC;
        end
      end
      cvt_pkg::S_EXEC: begin
        if (stat.action == cvt_pkg::ACT_REMOVE && !stat.pos_bad) begin
          state_nxt = cvt_pkg::S_SHIFT;
        end else begin
          state_nxt = cvt_pkg::S_RESULT;
        end
      end
      cvt_pkg::S_SHIFT: begin
        if (!stat.shift_more) begin
          state_nxt = cvt_pkg::S_RESULT;
        end
      end
      cvt_pkg::S_RESULT: begin
        if (stat.out_free) begin
          state_nxt = cvt_pkg::S_IDLE;
        end
      end
      default: state_nxt = cvt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = cvt_pkg::ST_OK;
    case (state_r)
      cvt_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load_in  = stat.in_valid;
      end
      cvt_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        case (stat.action)
          cvt_pkg::ACT_APPEND: begin
            if (stat.table_full) begin
              cmd.status = cvt_pkg::ST_FULL;
            end else begin
              cmd.do_append = 1'b1;
            end
          end
          cvt_pkg::ACT_READ: begin
            if (stat.pos_bad) begin
              cmd.status = cvt_pkg::ST_INDEX;
            end else begin
              cmd.do_read = 1'b1;
            end
          end
          cvt_pkg::ACT_WRITE: begin
            if (stat.pos_bad) begin
              cmd.status = cvt_pkg::ST_INDEX;
            end else begin
              cmd.do_write = 1'b1;
            end
          end
          cvt_pkg::ACT_REMOVE: begin
            if (stat.pos_bad) begin
              cmd.status = cvt_pkg::ST_INDEX;
            end else begin
              cmd.start_remove = 1'b1;
            end
          end
          default: cmd.status = cvt_pkg::ST_OK;
        endcase
      end
      cvt_pkg::S_SHIFT: begin
        cmd.do_shift      = stat.shift_more;
        cmd.finish_remove = !stat.shift_more;
      end
      cvt_pkg::S_RESULT: begin
        cmd.load_out = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/cvt_datapath.sv
// Datapath of the compacting vector table: entry memory, count, capacity,
// shift index and result register. Driven by cvt_ctrl; uses cvt_pkg.
module cvt_datapath #(
  parameter int DEPTH            = cvt_pkg::DEPTH_DEF,
  parameter int WORD_BITS        = cvt_pkg::WORD_BITS_DEF,
  parameter int INITIAL_CAPACITY = cvt_pkg::INIT_CAP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  cvt_in_if.sink             in_chan,
  cvt_out_if.source          out_chan,
  input  cvt_pkg::cvt_cmd_t  cmd,
  output cvt_pkg::cvt_stat_t stat
);

  localparam int CAP_MAX = (DEPTH > INITIAL_CAPACITY) ? DEPTH : INITIAL_CAPACITY;
  localparam int CW      = $clog2(CAP_MAX + 1);
  localparam int XW      = CW + 1;
  localparam int AW      = $clog2(DEPTH);
  localparam int PCW     = (CW > cvt_pkg::POSITION_W) ? CW : cvt_pkg::POSITION_W;

  logic [WORD_BITS-1:0]             mem_r [DEPTH];
  logic [WORD_BITS-1:0]             rd_data_r;
  cvt_pkg::action_t                 act_r;
  logic [cvt_pkg::POSITION_W-1:0]   pos_r;
  logic [cvt_pkg::VALUE_W-1:0]      val_r;
  cvt_pkg::status_t                 status_r;
  logic [CW-1:0]                    count_r;
  logic [CW-1:0]                    count_nxt;
  logic [CW-1:0]                    cap_r;
  logic [CW-1:0]                    cap_nxt;
  logic [AW-1:0]                    idx_r;
  logic [AW-1:0]                    idx_nxt;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic [cvt_pkg::READ_WORD_W-1:0]  out_word_r;
  logic [cvt_pkg::STATUS_W-1:0]     out_status_r;
  logic [cvt_pkg::COUNT_OUT_W-1:0]  out_count_r;
  logic [cvt_pkg::COUNT_OUT_W-1:0]  out_cap_r;

  logic                             wr_en;
  logic [AW-1:0]                    wr_addr;
  logic [WORD_BITS-1:0]             wr_data;
  logic                             rd_en;
  logic [AW-1:0]                    rd_addr;
  logic [XW-1:0]                    cap_dbl;
  logic [CW-1:0]                    cap_grown;
  logic [CW-1:0]                    count_dec;
  logic                             pos_bad;
  logic                             shift_more;

  assign pos_bad    = PCW'(pos_r) >= PCW'(count_r);
  assign shift_more = (XW'(idx_r) + XW'(1)) < XW'(count_r);

  always_comb begin
    stat            = '0;
    stat.in_valid   = in_chan.valid;
    stat.action     = act_r;
    stat.pos_bad    = pos_bad;
    stat.table_full = count_r == CW'(DEPTH);
    stat.shift_more = shift_more;
    stat.out_free   = !out_valid_r || out_chan.ready;
  end

  assign in_chan.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= cvt_pkg::action_t'(in_chan.action);
      pos_r <= in_chan.position;
      val_r <= in_chan.value;
    end
    if (cmd.exec) begin
      status_r <= cmd.status;
    end
  end

  assign wr_en   = cmd.do_append || cmd.do_write || cmd.do_shift;
  assign wr_data = cmd.do_shift ? rd_data_r : WORD_BITS'(val_r);
  assign rd_en   = cmd.do_read || cmd.start_remove || cmd.do_shift;

  always_comb begin
    wr_addr = idx_r;
    if (cmd.do_append) begin
      wr_addr = AW'(count_r);
    end else if (cmd.do_write) begin
      wr_addr = AW'(pos_r);
    end
  end

  always_comb begin
    rd_addr = idx_r + AW'(2);
    if (cmd.do_read) begin
      rd_addr = AW'(pos_r);
    end else if (cmd.start_remove) begin
      rd_addr = AW'(pos_r) + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign cap_dbl   = {cap_r, 1'b0};
  assign cap_grown = (cap_dbl > XW'(DEPTH)) ? CW'(DEPTH) : cap_dbl[CW-1:0];
  assign count_dec = count_r - CW'(1);

  always_comb begin
    count_nxt = count_r;
    cap_nxt   = cap_r;
    idx_nxt   = idx_r;
    if (cmd.do_append) begin
      count_nxt = count_r + CW'(1);
      if (count_r >= cap_r) begin
        cap_nxt = cap_grown;
      end
    end
    if (cmd.start_remove) begin
      idx_nxt = AW'(pos_r);
    end
    if (cmd.do_shift) begin
      idx_nxt = idx_r + AW'(1);
    end
    if (cmd.finish_remove) begin
      count_nxt = count_dec;
      if (count_dec != '0 && count_dec == (cap_r >> 2)) begin
        cap_nxt = cap_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CW'(INITIAL_CAPACITY);
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r   <= (act_r == cvt_pkg::ACT_READ && status_r == cvt_pkg::ST_OK)
                      ? cvt_pkg::READ_WORD_W'(rd_data_r) : '0;
      out_status_r <= status_r;
      out_count_r  <= cvt_pkg::COUNT_OUT_W'(count_r);
      out_cap_r    <= cvt_pkg::COUNT_OUT_W'(cap_r);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.read_word    = out_word_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.entry_count  = out_count_r;
  assign out_chan.capacity_now = out_cap_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("entry count exceeds capacity");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_shift |-> shift_more)
    else $error("shift step beyond the last entry");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish_remove |=> count_r == $past(count_r) - CW'(1))
    else $error("remove did not lower the count by one");

endmodule

// File: rtl/compacting_vector_table.sv
// Compacting vector table: top level joining cvt_ctrl and cvt_datapath.
// Append, read and write pass from IDLE through EXEC to RESULT, which loads the result;
// the next request is taken only back in IDLE, so one request is handled at a time.
// A remove at a valid position adds the SHIFT state, moving one entry per cycle.
// A result that is not taken holds the following request in its result state.
// Reset (rst_n, synchronous) clears the count and sets capacity to the initial value.
module compacting_vector_table #(
  parameter int DEPTH            = cvt_pkg::DEPTH_DEF,
  parameter int WORD_BITS        = cvt_pkg::WORD_BITS_DEF,
  parameter int INITIAL_CAPACITY = cvt_pkg::INIT_CAP_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cvt_in_if.sink    in_chan,
  cvt_out_if.source out_chan
);

  cvt_pkg::cvt_cmd_t  cmd;
  cvt_pkg::cvt_stat_t stat;

  cvt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  cvt_datapath #(
    .DEPTH            (DEPTH),
    .WORD_BITS        (WORD_BITS),
    .INITIAL_CAPACITY (INITIAL_CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// File: test/tb_compacting_vector_table.sv
// Testbench for compacting_vector_table: random and directed append, read, write
// and remove requests, each checked against a behavioral table kept in the bench.
// Depends on cvt_pkg and the cvt_in_if / cvt_out_if channel interfaces.
module tb_compacting_vector_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = cvt_pkg::DEPTH_DEF;
  localparam int START_CAP    = cvt_pkg::INIT_CAP_DEF;
  localparam int RANDOM_ITEMS = 830;
  localparam int MAX_IDLE     = 14;
  localparam int LONG_HOLD    = 150;
  localparam int SETTLE_TIME  = 200;

  typedef enum {GROW_PHASE, SHRINK_PHASE, ACCESS_PHASE} phase_t;

  typedef logic [cvt_pkg::POSITION_W-1:0]  pos_t;
  typedef logic [cvt_pkg::VALUE_W-1:0]     word_t;
  typedef logic [cvt_pkg::READ_WORD_W-1:0] rd_word_t;
  typedef logic [cvt_pkg::COUNT_OUT_W-1:0] count_t;

  typedef struct {
    cvt_pkg::action_t        action;
    pos_t                    position;
    word_t                   value;
    int                      idle;
  } request_t;

  typedef struct {
    rd_word_t                read_word;
    cvt_pkg::status_t        status;
    count_t                  entry_count;
    count_t                  capacity_now;
  } table_result_t;

  logic clk;
  logic rst_n;

  cvt_in_if  req_if ();
  cvt_out_if res_if ();

  compacting_vector_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if)
  );

  request_t      pending_requests[$];
  table_result_t expected_results[$];

  word_t shadow_words [TABLE_DEPTH];
  int shadow_count = 0;
  int shadow_cap   = START_CAP;
  int planned_count = 0;

  int n_queued   = 0;
  int n_offered  = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_errors   = 0;
  int n_full_rejects  = 0;
  int n_index_rejects = 0;
  int n_halvings      = 0;
  int peak_cap        = START_CAP;
  bit stall_receiver  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic table_result_t apply_request(cvt_pkg::action_t act, pos_t pos,
                                                  word_t val);
    table_result_t r;
    int i;
    r.read_word = '0;
    r.status    = cvt_pkg::ST_OK;
    if (act == cvt_pkg::ACT_APPEND) begin
      if (shadow_count >= TABLE_DEPTH) begin
        r.status = cvt_pkg::ST_FULL;
        n_full_rejects++;
      end else begin
        if (shadow_count >= shadow_cap)
          shadow_cap = (shadow_cap * 2 > TABLE_DEPTH) ? TABLE_DEPTH : shadow_cap * 2;
        shadow_words[shadow_count] = val;
        shadow_count++;
      end
    end else if (int'(pos) >= shadow_count) begin
      r.status = cvt_pkg::ST_INDEX;
      n_index_rejects++;
    end else begin
      case (act)
        cvt_pkg::ACT_READ: begin
          r.read_word = shadow_words[pos];
        end
        cvt_pkg::ACT_WRITE: begin
          shadow_words[pos] = val;
        end
        default: begin
          for (i = pos; i + 1 < shadow_count; i++)
            shadow_words[i] = shadow_words[i + 1];
          shadow_count--;
          if (shadow_count > 0 && shadow_count == shadow_cap / 4) begin
            shadow_cap = shadow_cap / 2;
            n_halvings++;
          end
        end
      endcase
    end
    if (shadow_cap > peak_cap)
      peak_cap = shadow_cap;
    r.entry_count  = shadow_count[cvt_pkg::COUNT_OUT_W-1:0];
    r.capacity_now = shadow_cap[cvt_pkg::COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  task automatic send(cvt_pkg::action_t act, int pos, word_t val, int idle);
    request_t r;
    r.action   = act;
    r.position = pos[cvt_pkg::POSITION_W-1:0];
    r.value    = val;
    r.idle     = idle;
    pending_requests.push_back(r);
    n_queued++;
    if (act == cvt_pkg::ACT_APPEND) begin
      if (planned_count < TABLE_DEPTH)
        planned_count++;
    end else if (act == cvt_pkg::ACT_REMOVE && pos < planned_count) begin
      planned_count--;
    end
  endtask

  task automatic wait_for_results();
    while (n_results < n_queued)
      @(posedge clk);
  endtask

  function automatic int pick_position(int live);
    int roll = $urandom_range(0, 99);
    if (live == 0 || roll < 12)
      return $urandom_range(0, TABLE_DEPTH - 1);
    if (roll < 20)
      return live - 1;
    if (roll < 26)
      return 0;
    return $urandom_range(0, live - 1);
  endfunction

  function automatic word_t pick_value();
    int roll = $urandom_range(0, 9);
    if (roll == 0)
      return '0;
    if (roll == 1)
      return '1;
    return $urandom;
  endfunction

  // Request driver: each queued item waits its idle cycles, then is offered until transferred.
  always @(negedge clk) begin : request_driver
    request_t cur;
    bit offering;
    bit staged;
    int idle_left;
    if (!rst_n) begin
      offering = 1'b0;
      staged   = 1'b0;
      idle_left = 0;
      req_if.valid    <= 1'b0;
      req_if.action   <= '0;
      req_if.position <= '0;
      req_if.value    <= '0;
    end else begin
      if (offering && n_accepted == n_offered)
        offering = 1'b0;
      if (!offering && !staged && pending_requests.size() > 0) begin
        cur = pending_requests.pop_front();
        idle_left = cur.idle;
        staged = 1'b1;
      end
      if (staged) begin
        if (idle_left > 0) begin
          idle_left--;
        end else begin
          staged = 1'b0;
          offering = 1'b1;
          n_offered++;
        end
      end
      req_if.valid    <= offering;
      req_if.action   <= offering ? cur.action : cvt_pkg::action_t'($urandom_range(0, 3));
      req_if.position <= offering ? cur.position : pos_t'($urandom);
      req_if.value    <= offering ? cur.value : word_t'($urandom);
    end
  end

  // Result receiver: alternates calm and choppy stretches, and holds off on request.
  always @(negedge clk) begin : result_receiver
    int hold_left;
    int seen_results;
    int mode_left;
    bit choppy;
    if (!rst_n) begin
      hold_left = 0;
      seen_results = 0;
      mode_left = 50;
      choppy = 1'b1;
      res_if.ready <= 1'b0;
    end else begin
      if (n_results != seen_results) begin
        seen_results = n_results;
        if (mode_left == 0) begin
          choppy = !choppy;
          mode_left = $urandom_range(30, 100);
        end else begin
          mode_left--;
        end
        hold_left = choppy ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall_receiver) begin
        stall_receiver = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    table_result_t want;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        expected_results.push_back(apply_request(cvt_pkg::action_t'(req_if.action),
                                                 req_if.position, req_if.value));
        n_accepted++;
      end
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d, entry_count %0d",
                 res_if.status, res_if.entry_count);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_word", want.read_word, res_if.read_word);
          check_field("status", want.status, res_if.status);
          check_field("entry_count", want.entry_count, res_if.entry_count);
          check_field("capacity_now", want.capacity_now, res_if.capacity_now);
        end
      end
    end
  end

  initial begin
    #(6_000_000);
    $display("tb_compacting_vector_table: done, errors");
    $finish;
  end

  initial begin : stimulus
    phase_t phase;
    cvt_pkg::action_t act;
    int phase_len;
    int idle_max;
    int roll;
    int i;
    int n;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table, growth from four to eight, halving down to two, index rejects.
    send(cvt_pkg::ACT_READ, 0, 32'hFFFF_FFFF, 0);
    send(cvt_pkg::ACT_REMOVE, 0, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_WRITE, 63, 32'h1234_5678, 0);
    send(cvt_pkg::ACT_APPEND, 0, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_APPEND, 63, 32'hFFFF_FFFF, 0);
    send(cvt_pkg::ACT_APPEND, 0, 32'hA5A5_A5A5, 0);
    send(cvt_pkg::ACT_APPEND, 0, 32'h5A5A_5A5A, 0);
    send(cvt_pkg::ACT_APPEND, 0, 32'h8000_0001, 0);
    send(cvt_pkg::ACT_READ, 1, 32'hDEAD_BEEF, 0);
    send(cvt_pkg::ACT_READ, 4, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_READ, 5, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_WRITE, 1, 32'h0F0F_F0F0, 0);
    send(cvt_pkg::ACT_READ, 1, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_REMOVE, 0, 32'hFFFF_FFFF, 0);
    send(cvt_pkg::ACT_REMOVE, 3, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_REMOVE, 4, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_REMOVE, 1, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_READ, 1, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_REMOVE, 0, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_REMOVE, 0, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_READ, 0, 32'h0000_0000, 0);

    // Fill past the top, touch the last entry, then drain at random positions.
    for (i = 0; i < TABLE_DEPTH + 3; i++)
      send(cvt_pkg::ACT_APPEND, $urandom_range(0, 63), pick_value(), $urandom_range(0, 2));
    send(cvt_pkg::ACT_READ, 63, pick_value(), 0);
    send(cvt_pkg::ACT_WRITE, 63, 32'hFFFF_FFFF, 0);
    send(cvt_pkg::ACT_READ, 63, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_REMOVE, 63, pick_value(), 0);
    send(cvt_pkg::ACT_APPEND, 0, 32'h0000_0000, 0);
    send(cvt_pkg::ACT_APPEND, 0, 32'hFFFF_FFFF, 0);
    while (planned_count > 0)
      send(cvt_pkg::ACT_REMOVE, $urandom_range(0, planned_count - 1), pick_value(),
           $urandom_range(0, MAX_IDLE));

    // Let the pipeline empty, then stall the receiver while requests keep coming.
    wait_for_results();
    stall_receiver = 1'b1;
    for (i = 0; i < 8; i++)
      send(cvt_pkg::ACT_APPEND, 0, pick_value(), 0);
    for (i = 0; i < 4; i++)
      send(cvt_pkg::ACT_READ, pick_position(planned_count), pick_value(), 0);

    for (n = 0; n < RANDOM_ITEMS; ) begin
      phase = phase_t'($urandom_range(0, 2));
      phase_len = $urandom_range(20, 80);
      idle_max = $urandom_range(0, 2) == 0 ? 0 : MAX_IDLE;
      for (i = 0; i < phase_len; i++, n++) begin
        roll = $urandom_range(0, 99);
        case (phase)
          GROW_PHASE:
            act = roll < 70 ? cvt_pkg::ACT_APPEND : roll < 80 ? cvt_pkg::ACT_READ :
                  roll < 90 ? cvt_pkg::ACT_WRITE : cvt_pkg::ACT_REMOVE;
          SHRINK_PHASE:
            act = roll < 15 ? cvt_pkg::ACT_APPEND : roll < 30 ? cvt_pkg::ACT_READ :
                  roll < 40 ? cvt_pkg::ACT_WRITE : cvt_pkg::ACT_REMOVE;
          default:
            act = roll < 25 ? cvt_pkg::ACT_APPEND : roll < 50 ? cvt_pkg::ACT_READ :
                  roll < 75 ? cvt_pkg::ACT_WRITE : cvt_pkg::ACT_REMOVE;
        endcase
        send(act, pick_position(planned_count), pick_value(), $urandom_range(0, idle_max));
      end
    end

    wait_for_results();
    repeat (SETTLE_TIME) @(posedge clk);
    $display("Checked %0d requests: %0d full-table drops, %0d index rejects.",
             n_accepted, n_full_rejects, n_index_rejects);
    $display("Capacity peaked at %0d and was halved %0d times.", peak_cap, n_halvings);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb_compacting_vector_table: done, clean");
    end else begin
      $display("tb_compacting_vector_table: done, errors");
    end
    $finish;
  end

endmodule
